/* hw/rtl/sats_pkg.sv */
// Shared types, codes and constants of the set-associative LRU tag store.
`default_nettype none
package sats_pkg;

    // Fixed field widths of the trace interface.
    localparam int ADDR_BITS = 32;
    localparam int TAG_W     = ADDR_BITS;
    localparam int CNT_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 5;

    // Defaults of the top-level parameters.
    localparam int SATS_MAX_SET_BITS = 6;
    localparam int SATS_MAX_WAYS     = 8;

    // Saturation limit of the block offset register.
    localparam int BLOCK_BITS_MAX = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_STORE  = 2'd1,
        KIND_MODIFY = 2'd2,
        KIND_IFETCH = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } t_outcome;

    typedef struct packed {
        t_kind                  kind;
        logic [ADDR_BITS-1:0]   address;
    } t_in_item;

    typedef struct packed {
        t_outcome               outcome;
        logic [CNT_W-1:0]       hit_total;
        logic [CNT_W-1:0]       miss_total;
        logic [CNT_W-1:0]       eviction_total;
        logic                   last_of_access;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_CLEAR  = 2'd0,
        ST_IDLE   = 2'd1,
        ST_EXEC   = 2'd2,
        ST_REREAD = 2'd3
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic clear;    // write one zeroed row of the clearing pass
        logic capture;  // latch the input beat and read its set
        logic reissue;  // read the latched set again
        logic exec;     // resolve the lookup, write the row back, load the result
        logic last;     // last result of this access
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic clr_last;  // clearing pass is at its final row
        logic out_free;  // result register can take a new beat
    } t_dp_status;

endpackage
`default_nettype wire

/* hw/rtl/sats_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sats_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                    i_wdata,
    input  wire logic                                i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                    o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/sats_ctrl.sv */
// Controller state machine of the tag store: clearing pass and lookup sequencing.
`default_nettype none
module sats_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire sats_pkg::t_kind        i_in_kind,
    output logic                        o_in_stall,
    input  wire sats_pkg::t_dp_status   i_status,
    output sats_pkg::t_dp_cmd           o_cmd
);
    import sats_pkg::*;

    t_state r_state, n_state;
    logic   r_modify, n_modify;
    logic   r_second, n_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_modify <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_modify <= n_modify;
            r_second <= n_second;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_modify   = r_modify;
        n_second   = r_second;
        o_in_stall = 1'b1;
        o_cmd      = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                // An instruction fetch is taken and dropped here.
                if (i_in_valid && i_in_kind != KIND_IFETCH) begin
                    o_cmd.capture = 1'b1;
                    n_modify      = (i_in_kind == KIND_MODIFY);
                    n_second      = 1'b0;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.last = !(r_modify && !r_second);
                if (i_status.out_free) begin
                    o_cmd.exec = 1'b1;
                    if (r_modify && !r_second) begin
                        n_second = 1'b1;
                        n_state  = ST_REREAD;
                    end else begin
                        n_state  = ST_IDLE;
                    end
                end
            end
            ST_REREAD: begin
                // The row written back last cycle is read again for the second lookup.
                o_cmd.reissue = 1'b1;
                n_state       = ST_EXEC;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

/* hw/rtl/sats_dp.sv */
// Datapath of the tag store: configuration, set RAM, LRU update, counters, result register.
`default_nettype none
module sats_dp #(
    parameter int MAX_SET_BITS = sats_pkg::SATS_MAX_SET_BITS,
    parameter int MAX_WAYS     = sats_pkg::SATS_MAX_WAYS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire sats_pkg::t_dp_cmd                  i_cmd,
    output sats_pkg::t_dp_status                    o_status,
    input  wire sats_pkg::t_in_item                 i_in_data,
    input  wire logic                               i_cfg_we,
    input  wire logic [sats_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [sats_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output sats_pkg::t_out_item                     o_out_data
);
    import sats_pkg::*;

    localparam int ROWS    = 1 << MAX_SET_BITS;
    localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_W  = WAY_W;
    localparam int RANK_LO = MAX_WAYS;
    localparam int TAG_LO  = MAX_WAYS * (1 + RANK_W);
    localparam int ROW_W   = MAX_WAYS * (1 + RANK_W + TAG_W);

    // Configuration registers.
    logic [2:0] r_set_bits;
    logic [4:0] r_blk_bits;
    logic [3:0] r_ways;

    logic [2:0] s_eff;
    logic [4:0] b_eff;
    logic [4:0] e_eff;
    logic [5:0] tag_shamt;

    assign s_eff = (int'(r_set_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : r_set_bits;
    assign b_eff = (int'(r_blk_bits) > BLOCK_BITS_MAX) ? 5'(BLOCK_BITS_MAX) : r_blk_bits;
    assign e_eff = (r_ways == 4'd0) ? 5'd1 :
                   (int'(r_ways) > MAX_WAYS) ? 5'(MAX_WAYS) : {1'b0, r_ways};
    assign tag_shamt = {3'd0, s_eff} + {1'b0, b_eff};

    // Set index of the incoming beat.
    logic [ADDR_BITS-1:0] in_shift;
    logic [SET_W-1:0]     set_mask;
    logic [SET_W-1:0]     in_set;

    assign in_shift = i_in_data.address >> b_eff;
    assign set_mask = SET_W'((32'd1 << s_eff) - 32'd1);
    assign in_set   = in_shift[SET_W-1:0] & set_mask;

    // Latched access.
    logic [ADDR_BITS-1:0] r_addr;
    logic [SET_W-1:0]     r_set;
    logic [TAG_W-1:0]     tag;

    assign tag = TAG_W'(r_addr >> tag_shamt);

    // Clearing pass row counter.
    logic [SET_W-1:0] r_clr_addr;

    // Set RAM: one row holds valid bits, ranks and tags of all ways.
    logic [ROW_W-1:0] rd_row, wr_row;
    logic             ram_we, ram_re;
    logic [SET_W-1:0] ram_waddr, ram_raddr;

    assign ram_re    = i_cmd.capture | i_cmd.reissue;
    assign ram_raddr = i_cmd.capture ? in_set : r_set;
    assign ram_we    = i_cmd.clear | i_cmd.exec;
    assign ram_waddr = i_cmd.clear ? r_clr_addr : r_set;

    sats_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_cmd.clear ? '0 : wr_row),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd_row)
    );

    // Lookup and LRU update on the row just read.
    logic [MAX_WAYS-1:0]  vld, n_vld;
    logic [RANK_W-1:0]    rnk   [MAX_WAYS];
    logic [RANK_W-1:0]    n_rnk [MAX_WAYS];
    logic [TAG_W-1:0]     tg    [MAX_WAYS];
    logic [TAG_W-1:0]     n_tg  [MAX_WAYS];
    logic                 hit_any, free_any;
    logic [WAY_W-1:0]     hit_way, free_way, pick, touched;
    logic [RANK_W-1:0]    mine;
    t_outcome             outcome;

    always_comb begin
        hit_any  = 1'b0;
        free_any = 1'b0;
        hit_way  = '0;
        free_way = '0;
        pick     = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            vld[w] = rd_row[w];
            rnk[w] = rd_row[RANK_LO + w*RANK_W +: RANK_W];
            tg[w]  = rd_row[TAG_LO + w*TAG_W +: TAG_W];
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (w < int'(e_eff) && vld[w] && tg[w] == tag && !hit_any) begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (w < int'(e_eff) && !vld[w] && !free_any) begin
                free_any = 1'b1;
                free_way = WAY_W'(w);
            end
        end
        // Lowest rank among the used ways, lowest way number on a tie.
        for (int w = 1; w < MAX_WAYS; w++) begin
            if (w < int'(e_eff) && rnk[w] < rnk[pick]) begin
                pick = WAY_W'(w);
            end
        end
        if (hit_any) begin
            touched = hit_way;
            outcome = OUT_HIT;
        end else if (free_any) begin
            touched = free_way;
            outcome = OUT_FILL;
        end else begin
            touched = pick;
            outcome = OUT_EVICT;
        end
        mine  = rnk[touched];
        n_vld = vld;
        if (!hit_any && free_any) begin
            n_vld[touched] = 1'b1;
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            n_tg[w]  = tg[w];
            n_rnk[w] = rnk[w];
            if (w < int'(e_eff) && n_vld[w] && rnk[w] > mine) begin
                n_rnk[w] = rnk[w] - 1'b1;
            end
        end
        n_rnk[touched] = RANK_W'(e_eff - 5'd1);
        if (!hit_any) begin
            n_tg[touched] = tag;
        end
        wr_row = '0;
        wr_row[MAX_WAYS-1:0] = n_vld;
        for (int w = 0; w < MAX_WAYS; w++) begin
            wr_row[RANK_LO + w*RANK_W +: RANK_W] = n_rnk[w];
            wr_row[TAG_LO + w*TAG_W +: TAG_W]    = n_tg[w];
        end
    end

    // Counters and result register.
    logic [CNT_W-1:0] r_hit, r_miss, r_evict;
    logic [CNT_W-1:0] n_hit, n_miss, n_evict;
    logic             r_out_valid;
    t_out_item        r_out_data;
    logic             out_taken;

    assign n_hit     = r_hit   + CNT_W'(i_cmd.exec && outcome == OUT_HIT);
    assign n_miss    = r_miss  + CNT_W'(i_cmd.exec && outcome != OUT_HIT);
    assign n_evict   = r_evict + CNT_W'(i_cmd.exec && outcome == OUT_EVICT);
    assign out_taken = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits  <= 3'd0;
            r_blk_bits  <= 5'd4;
            r_ways      <= 4'd1;
            r_hit       <= '0;
            r_miss      <= '0;
            r_evict     <= '0;
            r_out_valid <= 1'b0;
            r_clr_addr  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SET_BITS:   r_set_bits <= i_cfg_data[2:0];
                    CFG_BLOCK_BITS: r_blk_bits <= i_cfg_data[4:0];
                    CFG_WAYS:       r_ways     <= i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
            r_hit   <= n_hit;
            r_miss  <= n_miss;
            r_evict <= n_evict;
            if (i_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (out_taken) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr <= i_in_data.address;
            r_set  <= in_set;
        end
        if (i_cmd.exec) begin
            r_out_data.outcome        <= outcome;
            r_out_data.hit_total      <= n_hit;
            r_out_data.miss_total     <= n_miss;
            r_out_data.eviction_total <= n_evict;
            r_out_data.last_of_access <= i_cmd.last;
        end
    end

    assign o_status.clr_last = (r_clr_addr == SET_W'(ROWS - 1));
    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;

endmodule
`default_nettype wire

/* hw/rtl/set_assoc_lru_tag_store.sv */
// Top level of the set-associative LRU tag store.
//
// Each accepted trace beat is looked up in a set-associative tag store with LRU
// ranks, and each lookup returns one result beat with its outcome and the
// running hit, miss and eviction totals. Loads and stores give one result,
// a modify gives two (last_of_access marks the second), and an instruction
// fetch is accepted and gives none. Every lookup is a read-modify-write of one
// set row in a synchronous RAM: a load or store reads the row, then resolves
// the lookup and writes the row back; a modify does so twice, as its second
// lookup reads the row again; an instruction fetch does no lookup. A new beat
// is accepted while a result still waits on the output; a lookup only waits
// when the result register is still held. After reset the block runs a
// clearing pass over all 2**MAX_SET_BITS rows (64 by default) of the set RAM
// and stalls its input until it ends; configuration writes are taken at any
// time but must be made while the block is idle.
`default_nettype none
module set_assoc_lru_tag_store #(
    parameter int MAX_SET_BITS = sats_pkg::SATS_MAX_SET_BITS,
    parameter int MAX_WAYS     = sats_pkg::SATS_MAX_WAYS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire sats_pkg::t_in_item                 i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output sats_pkg::t_out_item                     o_out_data,
    input  wire logic                               i_cfg_we,
    input  wire logic [sats_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [sats_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import sats_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    sats_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_kind  (i_in_data.kind),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sats_dp #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire
